/* rtl/frac_pkg.sv */
`default_nettype none

package frac_pkg;

   typedef enum logic [0:0] {
      ALU_GCD,
      ALU_DIV
   } frac_alu_sel_type;

endpackage

`default_nettype wire

/* rtl/frac_req_if.sv */
`default_nettype none

interface frac_req_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] numerator_in;
   logic signed [DATA_WIDTH-1:0] denominator_in;

   modport source (output valid, output numerator_in, output denominator_in, input ready);
   modport sink (input valid, input numerator_in, input denominator_in, output ready);
endinterface

`default_nettype wire

/* rtl/frac_rsp_if.sv */
`default_nettype none

interface frac_rsp_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] numerator_out;
   logic signed [DATA_WIDTH-1:0] denominator_out;
   logic                         zero_denominator;

   modport source (output valid, output numerator_out, output denominator_out,
                   output zero_denominator, input ready);
   modport sink (input valid, input numerator_out, input denominator_out,
                 input zero_denominator, output ready);
endinterface

`default_nettype wire

/* rtl/fraction_reducer_core.sv */
// sequence: from req transfer to rsp valid, each item passes through the binary gcd loop
// and then two bit-serial divisions, all on one subtractor
// throughput: one item at a time, the next req transfer is taken once the result has
// moved into the output register
// reset: synchronous, active high, clears the sequencer and the output valid
`default_nettype none

module fraction_reducer_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   frac_req_if.sink   req,
   frac_rsp_if.source rsp
);
   import frac_pkg::*;

   logic                         res_valid, res_ready, res_zero;
   logic signed [DATA_WIDTH-1:0] res_num, res_den;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_num_ff, rsp_num_in;
   logic signed [DATA_WIDTH-1:0] rsp_den_ff, rsp_den_in;
   logic                         rsp_zero_ff, rsp_zero_in;

   frac_engine #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_num    (req.numerator_in),
      .in_den    (req.denominator_in),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_num   (res_num),
      .res_den   (res_den),
      .res_zero  (res_zero)
   );

   // output register frees the engine while a result waits
   assign res_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_zero_in  = rsp_zero_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = res_num;
         rsp_den_in   = res_den;
         rsp_zero_in  = res_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.numerator_out    = rsp_num_ff;
   assign rsp.denominator_out  = rsp_den_ff;
   assign rsp.zero_denominator = rsp_zero_ff;

endmodule

`default_nettype wire

/* rtl/frac_alu.sv */
`default_nettype none

module frac_alu #(
   parameter int DATA_WIDTH = 32
) (
   input  frac_pkg::frac_alu_sel_type sel,
   input  logic [DATA_WIDTH-1:0]      u_val,
   input  logic [DATA_WIDTH-1:0]      v_val,
   input  logic                       shift_in,
   output logic [DATA_WIDTH-1:0]      a_used,
   output logic [DATA_WIDTH-1:0]      diff,
   output logic                       ge
);
   import frac_pkg::*;

   logic [DATA_WIDTH:0] sub;

   // gcd compares u with v, division shifts the next dividend bit into the remainder
   always_comb begin
      case (sel)
         ALU_GCD: a_used = u_val;
         ALU_DIV: a_used = {u_val[DATA_WIDTH-2:0], shift_in};
         default: a_used = u_val;
      endcase
   end

   assign sub  = {1'b0, a_used} - {1'b0, v_val};
   assign diff = sub[DATA_WIDTH-1:0];
   assign ge   = ~sub[DATA_WIDTH];

endmodule

`default_nettype wire

/* rtl/frac_engine.sv */
`default_nettype none

module frac_engine #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] in_num,
   input  logic signed [DATA_WIDTH-1:0] in_den,
   output logic                         res_valid,
   input  logic                         res_ready,
   output logic signed [DATA_WIDTH-1:0] res_num,
   output logic signed [DATA_WIDTH-1:0] res_den,
   output logic                         res_zero
);
   import frac_pkg::*;

   localparam int CntWidth = $clog2(DATA_WIDTH);
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(DATA_WIDTH - 1);
   localparam logic [CntWidth-1:0] CntOne = CntWidth'(1);
   localparam logic [DATA_WIDTH-1:0] One = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
   localparam logic [DATA_WIDTH-1:0] Zero = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_SCALE,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] u_ff, u_in;
   logic [DATA_WIDTH-1:0] v_ff, v_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic                  num_neg_ff, num_neg_in;
   logic                  den_neg_ff, den_neg_in;
   logic                  zero_ff, zero_in;
   logic [CntWidth-1:0]   k_ff, k_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;

   logic [DATA_WIDTH-1:0] num_raw, den_raw, num_abs, den_abs;
   frac_alu_sel_type      alu_sel;
   logic                  alu_shift_in;
   logic [DATA_WIDTH-1:0] alu_a, alu_diff;
   logic                  alu_ge;

   assign num_raw = $unsigned(in_num);
   assign den_raw = $unsigned(in_den);
   assign num_abs = num_raw[DATA_WIDTH-1] ? (~num_raw + One) : num_raw;
   assign den_abs = den_raw[DATA_WIDTH-1] ? (~den_raw + One) : den_raw;

   assign alu_sel      = (state_ff == ST_GCD) ? ALU_GCD : ALU_DIV;
   assign alu_shift_in = (state_ff == ST_DIV_DEN) ? den_ff[DATA_WIDTH-1]
                                                  : num_ff[DATA_WIDTH-1];

   frac_alu #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_alu (
      .sel      (alu_sel),
      .u_val    (u_ff),
      .v_val    (v_ff),
      .shift_in (alu_shift_in),
      .a_used   (alu_a),
      .diff     (alu_diff),
      .ge       (alu_ge)
   );

   always_comb begin
      state_in   = state_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      num_neg_in = num_neg_ff;
      den_neg_in = den_neg_ff;
      zero_in    = zero_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               num_in     = num_abs;
               num_neg_in = num_raw[DATA_WIDTH-1];
               den_neg_in = den_raw[DATA_WIDTH-1];
               zero_in    = (den_raw == Zero);
               den_in     = (den_raw == Zero) ? One : den_abs;
               u_in       = num_abs;
               v_in       = (den_raw == Zero) ? One : den_abs;
               k_in       = '0;
               state_in   = ST_GCD;
            end
         end
         // binary gcd, one step per cycle
         ST_GCD: begin
            if (u_ff == Zero) begin
               state_in = ST_SCALE;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + CntOne;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (alu_ge) begin
               u_in = alu_diff;
            end else begin
               u_in = v_ff;
               v_in = u_ff;
            end
         end
         // restore the common power of two
         ST_SCALE: begin
            if (k_ff == '0) begin
               cnt_in   = CntMax;
               state_in = ST_DIV_NUM;
            end else begin
               v_in = v_ff << 1;
               k_in = k_ff - CntOne;
            end
         end
         ST_DIV_NUM: begin
            u_in   = alu_ge ? alu_diff : alu_a;
            num_in = {num_ff[DATA_WIDTH-2:0], alu_ge};
            cnt_in = cnt_ff - CntOne;
            if (cnt_ff == '0) begin
               u_in     = Zero;
               cnt_in   = CntMax;
               state_in = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            u_in   = alu_ge ? alu_diff : alu_a;
            den_in = {den_ff[DATA_WIDTH-2:0], alu_ge};
            cnt_in = cnt_ff - CntOne;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      u_ff       <= u_in;
      v_ff       <= v_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      num_neg_ff <= num_neg_in;
      den_neg_ff <= den_neg_in;
      zero_ff    <= zero_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_num   = $signed(num_neg_ff ? (~num_ff + One) : num_ff);
   assign res_den   = $signed(den_neg_ff ? (~den_ff + One) : den_ff);
   assign res_zero  = zero_ff;

`ifndef SYNTHESIS
   a_divisor_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (v_ff != Zero))
      else $error("gcd register is zero while busy");

   a_remainder_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_NUM || state_ff == ST_DIV_DEN) |-> (u_ff < v_ff))
      else $error("partial remainder not below divisor");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> (res_valid && $stable(res_num) && $stable(res_den)))
      else $error("result changed before transfer");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == ST_GCD))
      else $error("accepted item did not start gcd");
`endif

endmodule

`default_nettype wire
